@@ rtl/core/zph_pkg.sv @@
// ----------------------------------------------------------------------------
// zph_pkg
// Shared types and constants of the position hasher: item layout, command
// codes, controller states, step codes and the fixed slots of the key table.
// ----------------------------------------------------------------------------
package zph_pkg;

  localparam int unsigned KeyIdxW = 10;
  localparam int unsigned HashW   = 64;
  localparam int unsigned SqW     = 6;
  localparam int unsigned PendW   = 64;

  // Command carried in the input sideband.
  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_ADD   = 2'd2,
    CMD_MOVE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  // Fixed slots of the key table.
  localparam logic [KeyIdxW-1:0] SideSlot   = 10'd768;
  localparam logic [KeyIdxW-1:0] CastleSlot = 10'd769;
  localparam logic [KeyIdxW-1:0] EpSlot     = 10'd773;

  localparam logic [2:0] MaxKind = 3'd5;

  // Key reads of begin and move items, one pending bit per step.
  localparam logic [SqW-1:0] StepFrom    = 6'd0;
  localparam logic [SqW-1:0] StepTo      = 6'd1;
  localparam logic [SqW-1:0] StepCapture = 6'd2;
  localparam logic [SqW-1:0] StepSide    = 6'd3;
  localparam logic [SqW-1:0] StepWk      = 6'd4;
  localparam logic [SqW-1:0] StepWq      = 6'd5;
  localparam logic [SqW-1:0] StepBk      = 6'd6;
  localparam logic [SqW-1:0] StepBq      = 6'd7;
  localparam logic [SqW-1:0] StepEpOld   = 6'd8;
  localparam logic [SqW-1:0] StepEpNew   = 6'd9;

  typedef struct packed {
    cmd_e                command;
    logic [KeyIdxW-1:0]  key_index;
    logic [HashW-1:0]    data_word;
    logic                color;
    logic [2:0]          piece_kind;
    logic [2:0]          captured_kind;
    logic [SqW-1:0]      from_square;
    logic [SqW-1:0]      to_square;
    logic [3:0]          castle_rights;
    logic                ep_valid;
    logic [2:0]          ep_file;
  } item_t;

  typedef struct packed {
    logic capture;  // take the input item
    logic issue;    // read the next pending key
    logic commit;   // publish the result and update the position state
  } ctrl_cmd_t;

  typedef struct packed {
    logic pend_empty;
  } dp_status_t;

endpackage

@@ rtl/core/zph_ram.sv @@
// ----------------------------------------------------------------------------
// zph_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module zph_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 781
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/zph_ctrl.sv @@
// ----------------------------------------------------------------------------
// zph_ctrl
// Sequencer of the position hasher: takes an item, steps through its key
// reads and hands the result to the output register.
// ----------------------------------------------------------------------------
module zph_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_valid_i,
  output logic               s_ready_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  input  zph_pkg::dp_status_t status_i,
  output zph_pkg::ctrl_cmd_t  cmd_o
);

  zph_pkg::state_e state_q, state_d;
  logic            m_valid_q, m_valid_d;
  logic            out_free;

  assign out_free = !m_valid_q || m_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      zph_pkg::ST_IDLE: begin
        if (s_valid_i) begin
          state_d = zph_pkg::ST_RUN;
        end
      end
      zph_pkg::ST_RUN: begin
        if (status_i.pend_empty) begin
          state_d = zph_pkg::ST_FINISH;
        end
      end
      zph_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = zph_pkg::ST_IDLE;
        end
      end
      default: state_d = zph_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o     = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.issue   = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      zph_pkg::ST_IDLE: begin
        s_ready_o     = 1'b1;
        cmd_o.capture = s_valid_i;
      end
      zph_pkg::ST_RUN: begin
        cmd_o.issue = !status_i.pend_empty;
      end
      zph_pkg::ST_FINISH: begin
        cmd_o.commit = out_free;
      end
      default: begin
        s_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.commit) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= zph_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign m_valid_o = m_valid_q;

endmodule

@@ rtl/core/zph_datapath.sv @@
// ----------------------------------------------------------------------------
// zph_datapath
// Key table, pending-read mask, slot address generation, hash accumulator
// and the position state kept between items.
// ----------------------------------------------------------------------------
module zph_datapath #(
  parameter int unsigned KEY_ENTRIES = 781
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  zph_pkg::item_t                item_i,
  input  zph_pkg::ctrl_cmd_t            cmd_i,
  output zph_pkg::dp_status_t           status_o,
  output logic [zph_pkg::HashW-1:0]     hash_o
);

  localparam int unsigned AddrW = $clog2(KEY_ENTRIES);

  zph_pkg::item_t                 item_q;
  logic [zph_pkg::PendW-1:0]      pend_q, pend_d, pend_init;
  logic [zph_pkg::PendW-1:0]      pend_low;
  logic [zph_pkg::SqW-1:0]        step;
  logic                           rd_pend_q;
  logic [zph_pkg::HashW-1:0]      acc_q, acc_d;
  logic [zph_pkg::HashW-1:0]      hash_q, out_q;
  logic [3:0]                     last_castle_q;
  logic                           last_ep_valid_q;
  logic [2:0]                     last_ep_file_q;
  logic [3:0]                     castle_diff;
  logic [zph_pkg::KeyIdxW-1:0]    rd_slot;
  logic [zph_pkg::HashW-1:0]      rdata;
  logic                           load_we;
  logic                           piece_ok;
  logic                           capt_ok;

  // Key table write: load items with an index inside the table go straight into it when accepted.
  assign load_we = cmd_i.capture && (item_i.command == zph_pkg::CMD_LOAD) &&
                   ({22'd0, item_i.key_index} < 32'(KEY_ENTRIES));

  zph_ram #(
    .WIDTH (zph_pkg::HashW),
    .DEPTH (KEY_ENTRIES)
  ) u_key_table (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AddrW'(item_i.key_index)),
    .wdata_i (item_i.data_word),
    .re_i    (cmd_i.issue),
    .raddr_i (AddrW'(rd_slot)),
    .rdata_o (rdata)
  );

  // Pending reads of a new item.
  assign piece_ok    = (item_i.piece_kind <= zph_pkg::MaxKind);
  assign capt_ok     = (item_i.captured_kind <= zph_pkg::MaxKind);
  assign castle_diff = item_i.castle_rights ^ last_castle_q;

  always_comb begin
    pend_init = '0;
    unique case (item_i.command)
      zph_pkg::CMD_LOAD: begin
        pend_init = '0;
      end
      zph_pkg::CMD_BEGIN: begin
        pend_init[zph_pkg::StepSide]  = item_i.color;
        pend_init[zph_pkg::StepWk]    = item_i.castle_rights[3];
        pend_init[zph_pkg::StepWq]    = item_i.castle_rights[2];
        pend_init[zph_pkg::StepBk]    = item_i.castle_rights[1];
        pend_init[zph_pkg::StepBq]    = item_i.castle_rights[0];
        pend_init[zph_pkg::StepEpNew] = item_i.ep_valid;
      end
      zph_pkg::CMD_ADD: begin
        pend_init = piece_ok ? item_i.data_word : '0;
      end
      zph_pkg::CMD_MOVE: begin
        pend_init[zph_pkg::StepFrom]    = piece_ok;
        pend_init[zph_pkg::StepTo]      = piece_ok;
        pend_init[zph_pkg::StepCapture] = capt_ok;
        pend_init[zph_pkg::StepSide]    = 1'b1;
        pend_init[zph_pkg::StepWk]      = castle_diff[3];
        pend_init[zph_pkg::StepWq]      = castle_diff[2];
        pend_init[zph_pkg::StepBk]      = castle_diff[1];
        pend_init[zph_pkg::StepBq]      = castle_diff[0];
        pend_init[zph_pkg::StepEpOld]   = last_ep_valid_q;
        pend_init[zph_pkg::StepEpNew]   = item_i.ep_valid;
      end
      default: pend_init = '0;
    endcase
  end

  // Lowest pending bit and its position.
  assign pend_low = pend_q & (~pend_q + 1'b1);

  always_comb begin
    step = '0;
    for (int i = 0; i < zph_pkg::PendW; i++) begin
      if (pend_low[i]) begin
        step = step | zph_pkg::SqW'(i);
      end
    end
  end

  function automatic logic [zph_pkg::KeyIdxW-1:0] piece_slot(
    input logic                   color,
    input logic [2:0]             kind,
    input logic [zph_pkg::SqW-1:0] square
  );
    logic [3:0] base;
    base = color ? ({1'b0, kind} + 4'd6) : {1'b0, kind};
    return {base, square};
  endfunction

  always_comb begin
    rd_slot = zph_pkg::SideSlot;
    if (item_q.command == zph_pkg::CMD_ADD) begin
      rd_slot = piece_slot(item_q.color, item_q.piece_kind, step);
    end else begin
      unique case (step)
        zph_pkg::StepFrom:
          rd_slot = piece_slot(item_q.color, item_q.piece_kind, item_q.from_square);
        zph_pkg::StepTo:
          rd_slot = piece_slot(item_q.color, item_q.piece_kind, item_q.to_square);
        zph_pkg::StepCapture:
          rd_slot = piece_slot(!item_q.color, item_q.captured_kind, item_q.to_square);
        zph_pkg::StepSide:  rd_slot = zph_pkg::SideSlot;
        zph_pkg::StepWk:    rd_slot = zph_pkg::CastleSlot;
        zph_pkg::StepWq:    rd_slot = zph_pkg::CastleSlot + 10'd1;
        zph_pkg::StepBk:    rd_slot = zph_pkg::CastleSlot + 10'd2;
        zph_pkg::StepBq:    rd_slot = zph_pkg::CastleSlot + 10'd3;
        zph_pkg::StepEpOld: rd_slot = zph_pkg::EpSlot + {7'd0, last_ep_file_q};
        zph_pkg::StepEpNew: rd_slot = zph_pkg::EpSlot + {7'd0, item_q.ep_file};
        default:            rd_slot = zph_pkg::SideSlot;
      endcase
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (cmd_i.capture) begin
      pend_d = pend_init;
    end else if (cmd_i.issue) begin
      pend_d = pend_q & (pend_q - 1'b1);
    end
  end

  // Accumulator: seeded on capture, folded with each key in the cycle after
  // its read.
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.capture) begin
      acc_d = (item_i.command == zph_pkg::CMD_BEGIN) ? '1 : hash_q;
    end else if (rd_pend_q) begin
      acc_d = acc_q ^ rdata;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.commit) begin
      out_q <= acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q          <= '0;
      rd_pend_q       <= 1'b0;
      hash_q          <= '0;
      last_castle_q   <= '0;
      last_ep_valid_q <= 1'b0;
      last_ep_file_q  <= '0;
    end else begin
      pend_q    <= pend_d;
      rd_pend_q <= cmd_i.issue;
      if (cmd_i.commit) begin
        hash_q <= acc_q;
        if ((item_q.command == zph_pkg::CMD_BEGIN) ||
            (item_q.command == zph_pkg::CMD_MOVE)) begin
          last_castle_q   <= item_q.castle_rights;
          last_ep_valid_q <= item_q.ep_valid;
          last_ep_file_q  <= item_q.ep_file;
        end
      end
    end
  end

  assign status_o.pend_empty = (pend_q == '0);
  assign hash_o              = out_q;

endmodule

@@ rtl/core/zobrist_position_hasher.sv @@
// ----------------------------------------------------------------------------
// zobrist_position_hasher
// Incremental position hash over a loadable table of 64-bit random keys.
// ----------------------------------------------------------------------------
// Usage: the input stream carries one command per item in s_axis_tuser (load
// key, begin position, add piece bitboard, apply move) and the operands in
// s_axis_tdata. Keys must be loaded into the table before any item reads
// them. Every item, loads included, returns one item on the output stream:
// the running hash as it stands after that item.
// Flow: the block works on one item at a time. The idle state accepts an item,
// the run state reads the table once per needed key through its single read
// port, one key per cycle, and the finish state publishes the result. A load
// or an empty begin needs no key read, a move up to ten, and a bitboard item
// one per set square, so up to 64. The result sits in an output register, so
// the next item is accepted while it waits; a new result only waits for the
// register to be taken.
// Reset clears the hash, the stored castling and en-passant state and the
// output valid; the key table keeps its contents and must be loaded again.
// A stalled receiver holds the result stable and, once the next item is done,
// holds the block before it publishes that item's result.
// ----------------------------------------------------------------------------
module zobrist_position_hasher #(
  parameter int unsigned KEY_ENTRIES = 781
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // Fields from bit 0 up: key_index[9:0], data_word[73:10], color[74],
  // piece_kind[77:75], captured_kind[80:78], from_square[86:81],
  // to_square[92:87], castle_rights[96:93], ep_valid[97], ep_file[100:98],
  // zero padding[103:101].
  input  logic [103:0] s_axis_tdata,
  // Fields from bit 0 up: command[1:0].
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // Fields from bit 0 up: hash_key[63:0].
  output logic [63:0]  m_axis_tdata
);

  zph_pkg::item_t      item;
  zph_pkg::ctrl_cmd_t  cmd;
  zph_pkg::dp_status_t status;

  // Unpack the input item.
  always_comb begin
    item.command       = zph_pkg::cmd_e'(s_axis_tuser);
    item.key_index     = s_axis_tdata[9:0];
    item.data_word     = s_axis_tdata[73:10];
    item.color         = s_axis_tdata[74];
    item.piece_kind    = s_axis_tdata[77:75];
    item.captured_kind = s_axis_tdata[80:78];
    item.from_square   = s_axis_tdata[86:81];
    item.to_square     = s_axis_tdata[92:87];
    item.castle_rights = s_axis_tdata[96:93];
    item.ep_valid      = s_axis_tdata[97];
    item.ep_file       = s_axis_tdata[100:98];
  end

  // The controller sequences an item; of the datapath it only sees command and status.
  zph_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // The datapath holds the key table, the hash and the position state.
  zph_datapath #(
    .KEY_ENTRIES (KEY_ENTRIES)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item),
    .cmd_i    (cmd),
    .status_o (status),
    .hash_o   (m_axis_tdata)
  );

endmodule

@@ sim/zobrist_position_hasher_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zobrist_position_hasher_test
// Self-checking bench for the position hasher. It first fills the whole key
// table with random keys. A steady stretch and one long receiver stall fall
// into this loading phase. A short table of hand-picked items follows, and
// then a random mix of load, begin, add and move items. An in-bench model of
// the hash state or a hand-picked row gives each returned hash, which is
// checked in order against the output stream. Both sides idle at random.
// ----------------------------------------------------------------------------
module zobrist_position_hasher_test;

  localparam int unsigned KEY_ENTRIES  = 781;
  localparam int          IDLE_PCT     = 17;
  localparam int          RANDOM_ITEMS = 50;
  localparam int          STALL_CYCLES = 300;
  localparam int          DRAIN_CYCLES = 80;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam logic [63:0] AllOnes      = '1;

  typedef struct {
    zph_pkg::item_t stim;
    bit             typed;
    logic [63:0]    hash;
  } stim_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;

  // Copy of the offered item, kept in step with the stream signals.
  zph_pkg::item_t offered_item;
  bit             offered_typed;
  logic [63:0]    offered_hash;

  // Model of the block's state.
  logic [63:0]  key_store [0:KEY_ENTRIES-1];
  logic [63:0]  pos_hash;
  logic [3:0]   pos_castle;
  logic         pos_ep_valid;
  logic [2:0]   pos_ep_file;

  logic [63:0]  hashes_due [$];
  stim_row_t    directed_rows [$];
  int           error_count;
  int           cycle_count;
  bit           steady_mode;
  bit           hold_request;
  bit           hold_done;
  int           stall_left;

  zobrist_position_hasher #(
    .KEY_ENTRIES(KEY_ENTRIES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [63:0] square_key(logic color, logic [2:0] kind,
                                             logic [5:0] square);
    if (kind > zph_pkg::MaxKind) begin
      return '0;
    end
    return key_store[(int'(color) * 6 + int'(kind)) * 64 + int'(square)];
  endfunction

  function automatic logic [63:0] castle_keys(logic [3:0] rights);
    logic [63:0] k;
    k = '0;
    if (rights[3]) k ^= key_store[int'(zph_pkg::CastleSlot)];
    if (rights[2]) k ^= key_store[int'(zph_pkg::CastleSlot) + 1];
    if (rights[1]) k ^= key_store[int'(zph_pkg::CastleSlot) + 2];
    if (rights[0]) k ^= key_store[int'(zph_pkg::CastleSlot) + 3];
    return k;
  endfunction

  // Applies one accepted item to the modeled position and returns the hash
  // that the block must report for it.
  task automatic fold_item_into_hash(input zph_pkg::item_t it, output logic [63:0] hash);
    logic [63:0] h;
    h = pos_hash;
    case (it.command)
      zph_pkg::CMD_LOAD: begin
        if (it.key_index < KEY_ENTRIES) key_store[it.key_index] = it.data_word;
      end
      zph_pkg::CMD_BEGIN: begin
        h = AllOnes;
        if (it.color) h ^= key_store[int'(zph_pkg::SideSlot)];
        h ^= castle_keys(it.castle_rights);
        if (it.ep_valid) h ^= key_store[int'(zph_pkg::EpSlot) + int'(it.ep_file)];
        pos_castle   = it.castle_rights;
        pos_ep_valid = it.ep_valid;
        pos_ep_file  = it.ep_file;
      end
      zph_pkg::CMD_ADD: begin
        for (int n = 0; n < 64; n++) begin
          if (it.data_word[n]) h ^= square_key(it.color, it.piece_kind, 6'(n));
        end
      end
      default: begin
        h ^= square_key(it.color, it.piece_kind, it.from_square);
        h ^= square_key(it.color, it.piece_kind, it.to_square);
        // The captured piece belongs to the other side.
        if (it.captured_kind <= zph_pkg::MaxKind) begin
          h ^= square_key(~it.color, it.captured_kind, it.to_square);
        end
        h ^= key_store[int'(zph_pkg::SideSlot)];
        h ^= castle_keys(it.castle_rights ^ pos_castle);
        if (pos_ep_valid) h ^= key_store[int'(zph_pkg::EpSlot) + int'(pos_ep_file)];
        if (it.ep_valid) h ^= key_store[int'(zph_pkg::EpSlot) + int'(it.ep_file)];
        pos_castle   = it.castle_rights;
        pos_ep_valid = it.ep_valid;
        pos_ep_file  = it.ep_file;
      end
    endcase
    pos_hash = h;
    hash     = h;
  endtask

  function automatic stim_row_t make_row(zph_pkg::cmd_e cmd, logic [9:0] idx,
                                         logic [63:0] data, logic color,
                                         logic [2:0] kind, logic [2:0] capt,
                                         logic [5:0] from_sq, logic [5:0] to_sq,
                                         logic [3:0] castle, logic epv, logic [2:0] epf,
                                         bit typed, logic [63:0] hash);
    stim_row_t r;
    r.stim.command       = cmd;
    r.stim.key_index     = idx;
    r.stim.data_word     = data;
    r.stim.color         = color;
    r.stim.piece_kind    = kind;
    r.stim.captured_kind = capt;
    r.stim.from_square   = from_sq;
    r.stim.to_square     = to_sq;
    r.stim.castle_rights = castle;
    r.stim.ep_valid      = epv;
    r.stim.ep_file       = epf;
    r.typed              = typed;
    r.hash               = hash;
    return r;
  endfunction

  // All fields random, then the command and its operands shaped so that most
  // items do real work; unused fields keep their random contents.
  function automatic zph_pkg::item_t random_item();
    zph_pkg::item_t it;
    int             pick;
    int             n_bits;
    int             k;
    it.command       = zph_pkg::CMD_LOAD;
    it.key_index     = 10'($urandom_range(0, 1023));
    it.data_word     = {$urandom, $urandom};
    it.color         = 1'($urandom_range(0, 1));
    it.piece_kind    = 3'($urandom_range(0, 5));
    it.captured_kind = 3'($urandom_range(0, 7));
    it.from_square   = 6'($urandom_range(0, 63));
    it.to_square     = 6'($urandom_range(0, 63));
    it.castle_rights = 4'($urandom_range(0, 15));
    it.ep_valid      = 1'($urandom_range(0, 1));
    it.ep_file       = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 9) == 0) it.piece_kind = 3'($urandom_range(6, 7));
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // Mostly real slots; now and then a random index that can lie past the table.
      if ($urandom_range(0, 9) != 0) it.key_index = 10'($urandom_range(0, KEY_ENTRIES - 1));
    end else if (pick < 25) begin
      it.command = zph_pkg::CMD_BEGIN;
    end else if (pick < 50) begin
      it.command = zph_pkg::CMD_ADD;
      k = $urandom_range(0, 19);
      if (k == 0) begin
        it.data_word = AllOnes;
      end else if (k > 2) begin
        // Sparse boards keep the per-item key reads short.
        it.data_word = '0;
        n_bits = $urandom_range(0, 6);
        for (k = 0; k < n_bits; k++) it.data_word[$urandom_range(0, 63)] = 1'b1;
      end
    end else begin
      it.command = zph_pkg::CMD_MOVE;
    end
    return it;
  endfunction

  task automatic offer(input zph_pkg::item_t it, input bit typed, input logic [63:0] hash);
    if (!steady_mode) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.command;
    s_axis_tdata  <= {3'b000, it.ep_file, it.ep_valid, it.castle_rights, it.to_square,
                      it.from_square, it.captured_kind, it.piece_kind, it.color,
                      it.data_word, it.key_index};
    offered_item  <= it;
    offered_typed <= typed;
    offered_hash  <= hash;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Input acceptance feeds the model; output acceptance is checked in order.
  always @(posedge clk_i) begin : track_hashes
    logic [63:0] predicted;
    logic [63:0] due;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      fold_item_into_hash(offered_item, predicted);
      hashes_due.push_back(offered_typed ? offered_hash : predicted);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (hashes_due.size() == 0) begin
        $display("%0t: unexpected hash item, actual %h", $realtime, m_axis_tdata);
        error_count++;
      end else begin
        due = hashes_due.pop_front();
        if (m_axis_tdata !== due) begin
          $display("%0t: hash_key mismatch, expected %h actual %h",
                   $realtime, due, m_axis_tdata);
          error_count++;
        end
      end
    end
  end

  // Receiver: random back-pressure, a steady stretch, and one long hold-off.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        stall_left = STALL_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (steady_mode) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    zph_pkg::item_t it;
    error_count   = 0;
    cycle_count   = 0;
    steady_mode   = 1'b0;
    hold_request  = 1'b0;
    hold_done     = 1'b0;
    stall_left    = 0;
    pos_hash      = '0;
    pos_castle    = '0;
    pos_ep_valid  = 1'b0;
    pos_ep_file   = '0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= zph_pkg::CMD_LOAD;
    offered_typed <= 1'b0;
    offered_hash  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every slot gets a key before anything reads the table. The loads also
    // carry the steady stretch and the long receiver stall.
    for (int slot = 0; slot < KEY_ENTRIES; slot++) begin
      steady_mode = (slot >= 300 && slot < 500);
      if (slot == 600) hold_request = 1'b1;
      it = random_item();
      it.command   = zph_pkg::CMD_LOAD;
      it.key_index = 10'(slot);
      offer(it, 1'b0, '0);
    end
    steady_mode = 1'b0;

    // Hand-picked items. Loads leave the hash at its reset value of zero
    // until the first begin, and an empty begin gives all ones.
    directed_rows.push_back(make_row(zph_pkg::CMD_LOAD, 10'd1023, AllOnes,
                                     0, 0, 0, 0, 0, 0, 0, 0, 1, '0));
    directed_rows.push_back(make_row(zph_pkg::CMD_LOAD, 10'd781, '0,
                                     0, 0, 0, 0, 0, 0, 0, 0, 1, '0));
    directed_rows.push_back(make_row(zph_pkg::CMD_BEGIN, 0, '0,
                                     0, 0, 0, 0, 0, 4'd0, 0, 0, 1, AllOnes));
    directed_rows.push_back(make_row(zph_pkg::CMD_ADD, 0, '0,
                                     0, 0, 0, 0, 0, 0, 0, 0, 1, AllOnes));
    // Piece kinds past the king add nothing, even on a full board.
    directed_rows.push_back(make_row(zph_pkg::CMD_ADD, 0, AllOnes,
                                     0, 3'd6, 0, 0, 0, 0, 0, 0, 1, AllOnes));
    directed_rows.push_back(make_row(zph_pkg::CMD_ADD, 0, AllOnes,
                                     1, 3'd7, 0, 0, 0, 0, 0, 0, 1, AllOnes));
    directed_rows.push_back(make_row(zph_pkg::CMD_LOAD, zph_pkg::SideSlot, '0,
                                     0, 0, 0, 0, 0, 0, 0, 0, 1, AllOnes));
    directed_rows.push_back(make_row(zph_pkg::CMD_LOAD, 10'd0, AllOnes,
                                     0, 0, 0, 0, 0, 0, 0, 0, 1, AllOnes));
    directed_rows.push_back(make_row(zph_pkg::CMD_LOAD, 10'd780, AllOnes,
                                     0, 0, 0, 0, 0, 0, 0, 0, 1, AllOnes));
    directed_rows.push_back(make_row(zph_pkg::CMD_BEGIN, 0, '0,
                                     1, 0, 0, 0, 0, 4'd15, 1, 3'd7, 0, '0));
    directed_rows.push_back(make_row(zph_pkg::CMD_ADD, 0, AllOnes,
                                     0, 3'd0, 0, 0, 0, 0, 0, 0, 0, '0));
    directed_rows.push_back(make_row(zph_pkg::CMD_ADD, 0, 64'h8000_0000_0000_0000,
                                     1, 3'd5, 0, 0, 0, 0, 0, 0, 0, '0));
    // Moves: corner to corner, captures of several kinds, no capture, and
    // castling and en-passant state switching both ways.
    directed_rows.push_back(make_row(zph_pkg::CMD_MOVE, 0, '0,
                                     0, 3'd0, 3'd6, 6'd0, 6'd63, 4'd15, 0, 3'd0, 0, '0));
    directed_rows.push_back(make_row(zph_pkg::CMD_MOVE, 0, '0,
                                     1, 3'd5, 3'd0, 6'd63, 6'd0, 4'd0, 1, 3'd0, 0, '0));
    directed_rows.push_back(make_row(zph_pkg::CMD_MOVE, 0, '0,
                                     0, 3'd3, 3'd5, 6'd12, 6'd28, 4'd5, 1, 3'd7, 0, '0));
    directed_rows.push_back(make_row(zph_pkg::CMD_MOVE, 0, '0,
                                     1, 3'd6, 3'd7, 6'd7, 6'd56, 4'd10, 0, 3'd3, 0, '0));
    directed_rows.push_back(make_row(zph_pkg::CMD_MOVE, 0, '0,
                                     0, 3'd7, 3'd6, 6'd33, 6'd34, 4'd10, 1, 3'd4, 0, '0));
    directed_rows.push_back(make_row(zph_pkg::CMD_BEGIN, 0, '0,
                                     0, 0, 0, 0, 0, 4'd9, 0, 3'd5, 0, '0));
    directed_rows.push_back(make_row(zph_pkg::CMD_LOAD, zph_pkg::SideSlot,
                                     64'h0123_4567_89AB_CDEF,
                                     0, 0, 0, 0, 0, 0, 0, 0, 0, '0));
    directed_rows.push_back(make_row(zph_pkg::CMD_MOVE, 0, '0,
                                     0, 3'd1, 3'd4, 6'd6, 6'd21, 4'd9, 0, 3'd0, 0, '0));
    directed_rows.push_back(make_row(zph_pkg::CMD_ADD, 0, 64'h8000_0000_0000_0001,
                                     1, 3'd2, 0, 0, 0, 0, 0, 0, 0, '0));
    foreach (directed_rows[i]) begin
      offer(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].hash);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      offer(random_item(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (hashes_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ zobrist_position_hasher.f @@
rtl/core/zph_pkg.sv
rtl/core/zph_ram.sv
rtl/core/zph_ctrl.sv
rtl/core/zph_datapath.sv
rtl/core/zobrist_position_hasher.sv
sim/zobrist_position_hasher_test.sv
